// ===== rtl/mtu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI to USB event packetizer - shared types and constants
// Byte codes, code index numbers and the records passed between stages.
// ----------------------------------------------------------------------------
package mtu_pkg;

   localparam logic [7:0] SYSEX_START  = 8'hF0;
   localparam logic [7:0] SYSEX_END    = 8'hF7;
   localparam logic [7:0] MTC_QUARTER  = 8'hF1;
   localparam logic [7:0] SONG_POS     = 8'hF2;
   localparam logic [7:0] SONG_SEL     = 8'hF3;
   localparam logic [7:0] REALTIME_MIN = 8'hF8;

   localparam logic [3:0] CIN_COMMON_2 = 4'h2;
   localparam logic [3:0] CIN_COMMON_3 = 4'h3;
   localparam logic [3:0] CIN_SYSEX    = 4'h4;
   localparam logic [3:0] CIN_SINGLE   = 4'h5;
   localparam logic [3:0] CIN_VOICE    = 4'h8;

   localparam logic [3:0] HI_PROG_CHG  = 4'hC;
   localparam logic [3:0] HI_CHAN_PRES = 4'hE - 4'h1;

   typedef struct packed {
      logic       valid;
      logic [7:0] midi_byte;
   } beat_type;

   typedef struct packed {
      logic [3:0] code_index;
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [7:0] byte2;
   } packet_type;

   function automatic logic [1:0] voice_length(input logic [7:0] status);
      logic [3:0] hi;
      hi = status[7:4];
      voice_length = (hi == HI_PROG_CHG || hi == HI_CHAN_PRES) ? 2'd2 : 2'd3;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/mtu_input_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI to USB event packetizer - input register
// Captures one MIDI byte per beat and holds it until the core takes it.
// ----------------------------------------------------------------------------
module mtu_input_stage (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic [7:0]    req_midi_byte,
   output logic               req_stall,
   input  wire logic          advance,
   output mtu_pkg::beat_type  beat
);
   import mtu_pkg::*;

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       take;

   assign req_stall = valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   always_comb begin
      valid_in = take ? 1'b1 : (valid_ff && !advance);
      byte_in  = take ? req_midi_byte : byte_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign beat.valid     = valid_ff;
   assign beat.midi_byte = byte_ff;

endmodule
`default_nettype wire

// ===== rtl/mtu_event_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI to USB event packetizer - packet assembly core
// Running status, SysEx chunking and system common assembly, one byte a cycle while advance is high.
// ----------------------------------------------------------------------------
module mtu_event_core (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          advance,
   input  mtu_pkg::beat_type  beat,
   output logic               emit,
   output mtu_pkg::packet_type packet
);
   import mtu_pkg::*;

   logic [1:0] fill_ff, fill_in;
   logic [1:0] expect_ff, expect_in;
   logic       sysex_ff, sysex_in;
   logic [7:0] status_ff, status_in;
   logic [6:0] saved_ff, saved_in;
   logic       saved_valid_ff, saved_valid_in;
   logic [3:0] header_ff, header_in;
   logic [7:0] pbytes_ff [3];
   logic [7:0] pbytes_in [3];

   logic [7:0] b;
   logic [1:0] idx;
   logic [1:0] count;
   logic [7:0] wr [3];
   logic [3:0] hdr_e;
   logic [1:0] exp_e;
   logic       sv_e;
   logic       drop;

   always_comb begin
      b     = beat.midi_byte;
      idx   = (fill_ff == 2'd3) ? 2'd2 : fill_ff;
      count = idx + 2'd1;
      wr    = pbytes_ff;
      wr[idx] = b;

      fill_in        = fill_ff;
      expect_in      = expect_ff;
      sysex_in       = sysex_ff;
      status_in      = status_ff;
      saved_in       = saved_ff;
      saved_valid_in = saved_valid_ff;
      header_in      = header_ff;
      pbytes_in      = pbytes_ff;
      hdr_e          = header_ff;
      exp_e          = expect_ff;
      sv_e           = saved_valid_ff;
      drop           = 1'b0;
      emit           = 1'b0;
      packet         = '0;

      if (b >= REALTIME_MIN) begin
         emit         = 1'b1;
         packet.code_index = CIN_SINGLE;
         packet.byte0 = b;
      end else if (b == SYSEX_END && sysex_ff) begin
         pbytes_in = wr;
         fill_in   = 2'd0;
         sysex_in  = 1'b0;
         emit      = 1'b1;
         packet.code_index = CIN_SYSEX + {2'b00, count};
         packet.byte0 = wr[0];
         packet.byte1 = (count > 2'd1) ? wr[1] : 8'h00;
         packet.byte2 = (count > 2'd2) ? wr[2] : 8'h00;
      end else if (b[7]) begin
         fill_in        = 2'd0;
         sysex_in       = 1'b0;
         saved_valid_in = 1'b0;
         if (b < SYSEX_START) begin
            status_in = b;
            header_in = b[7:4];
            expect_in = voice_length(b);
            fill_in   = 2'd1;
         end else begin
            status_in = 8'h00;
            if (b == SYSEX_START) begin
               sysex_in     = 1'b1;
               pbytes_in[0] = b;
               header_in    = CIN_SYSEX;
               expect_in    = 2'd3;
               fill_in      = 2'd1;
            end else if (b == MTC_QUARTER || b == SONG_POS || b == SONG_SEL) begin
               pbytes_in[0] = b;
               header_in    = (b == SONG_POS) ? CIN_COMMON_3 : CIN_COMMON_2;
               expect_in    = (b == SONG_POS) ? 2'd3 : 2'd2;
               fill_in      = 2'd1;
            end else begin
               emit         = 1'b1;
               packet.code_index = CIN_SINGLE;
               packet.byte0 = b;
            end
         end
      end else if (sysex_ff) begin
         pbytes_in = wr;
         if (count == 2'd3) begin
            fill_in = 2'd0;
            emit    = 1'b1;
            packet.code_index = CIN_SYSEX;
            packet.byte0 = wr[0];
            packet.byte1 = wr[1];
            packet.byte2 = wr[2];
         end else begin
            fill_in = count;
         end
      end else begin
         if (fill_ff == 2'd0) begin
            if (status_ff == 8'h00) begin
               drop = 1'b1;
            end else begin
               hdr_e          = status_ff[7:4];
               exp_e          = voice_length(status_ff);
               sv_e           = 1'b0;
               header_in      = hdr_e;
               expect_in      = exp_e;
               saved_valid_in = 1'b0;
               fill_in        = 2'd1;
            end
         end
         if (!drop) begin
            if (hdr_e >= CIN_VOICE) begin
               if (exp_e == 2'd2) begin
                  fill_in = 2'd0;
                  emit    = 1'b1;
                  packet.code_index = hdr_e;
                  packet.byte0 = status_ff;
                  packet.byte1 = b;
               end else if (!sv_e) begin
                  saved_in       = b[6:0];
                  saved_valid_in = 1'b1;
                  fill_in        = 2'd2;
               end else begin
                  saved_valid_in = 1'b0;
                  fill_in        = 2'd0;
                  emit           = 1'b1;
                  packet.code_index = hdr_e;
                  packet.byte0 = status_ff;
                  packet.byte1 = {1'b0, saved_ff};
                  packet.byte2 = b;
               end
            end else begin
               pbytes_in = wr;
               if (count >= exp_e) begin
                  fill_in = 2'd0;
                  emit    = 1'b1;
                  packet.code_index = hdr_e;
                  packet.byte0 = wr[0];
                  packet.byte1 = (count > 2'd1) ? wr[1] : 8'h00;
                  packet.byte2 = (count > 2'd2) ? wr[2] : 8'h00;
               end else begin
                  fill_in = count;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff        <= 2'd0;
         expect_ff      <= 2'd0;
         sysex_ff       <= 1'b0;
         status_ff      <= 8'h00;
         saved_ff       <= 7'h00;
         saved_valid_ff <= 1'b0;
         header_ff      <= 4'h0;
         pbytes_ff      <= '{default: 8'h00};
      end else if (advance) begin
         fill_ff        <= fill_in;
         expect_ff      <= expect_in;
         sysex_ff       <= sysex_in;
         status_ff      <= status_in;
         saved_ff       <= saved_in;
         saved_valid_ff <= saved_valid_in;
         header_ff      <= header_in;
         pbytes_ff      <= pbytes_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/mtu_output_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI to USB event packetizer - result register
// Holds one finished event packet until the downstream side takes the beat.
// ----------------------------------------------------------------------------
module mtu_output_stage (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           load,
   input  mtu_pkg::packet_type packet,
   output logic                ready,
   output logic                rsp_valid,
   input  wire logic           rsp_stall,
   output mtu_pkg::packet_type rsp_packet
);
   import mtu_pkg::*;

   logic       valid_ff, valid_in;
   packet_type packet_ff, packet_in;

   assign ready = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in  = load ? 1'b1 : (valid_ff && rsp_stall);
      packet_in = load ? packet : packet_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      packet_ff <= packet_in;
   end

   assign rsp_valid  = valid_ff;
   assign rsp_packet = packet_ff;

endmodule
`default_nettype wire

// ===== rtl/midi_to_usb_event_packetizer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI to USB event packetizer
// An accepted byte waits in the input register, then its packet in the result register.
// Throughput: one MIDI byte per cycle while the receiver does not stall.
// A byte that completes no packet still advances the core, without loading a result.
// Reset (synchronous) clears the stage valids and all packetizer state.
// ----------------------------------------------------------------------------
module midi_to_usb_event_packetizer (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_midi_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [3:0]      rsp_code_index,
   output logic [7:0]      rsp_byte0,
   output logic [7:0]      rsp_byte1,
   output logic [7:0]      rsp_byte2
);
   import mtu_pkg::*;

   beat_type   beat;
   packet_type packet;
   packet_type rsp_packet;
   logic       emit;
   logic       ready;
   logic       advance;

   assign advance = beat.valid && ready;

   mtu_input_stage u_input (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_midi_byte (req_midi_byte),
      .req_stall     (req_stall),
      .advance       (advance),
      .beat          (beat)
   );

   mtu_event_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .beat    (beat),
      .emit    (emit),
      .packet  (packet)
   );

   mtu_output_stage u_output (
      .clock      (clock),
      .reset      (reset),
      .load       (advance && emit),
      .packet     (packet),
      .ready      (ready),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_packet (rsp_packet)
   );

   assign rsp_code_index = rsp_packet.code_index;
   assign rsp_byte0      = rsp_packet.byte0;
   assign rsp_byte1      = rsp_packet.byte1;
   assign rsp_byte2      = rsp_packet.byte2;

   a_reset_clears : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_cin_legal : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_code_index != 4'h0 && rsp_code_index != 4'h1 &&
                    rsp_code_index != 4'hF)
      else $error("illegal code index");

   a_voice_header : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_code_index >= CIN_VOICE |->
         rsp_byte0[7:4] == rsp_code_index && !rsp_byte1[7])
      else $error("voice packet header does not match status");

   a_single_status : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_code_index == CIN_SINGLE |->
         rsp_byte0[7] && rsp_byte1 == 8'h00 && rsp_byte2 == 8'h00)
      else $error("single-byte packet malformed");

endmodule
`default_nettype wire

// ===== bench/midi_to_usb_event_packetizer_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI to USB event packetizer - packet checker
// Watches both channels, rebuilds the expected USB-MIDI event packets from
// the accepted MIDI bytes and compares them in order with the packets that
// leave the block. Hands its counts to the bench top.
// ----------------------------------------------------------------------------
module midi_to_usb_event_packetizer_check (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_stall,
   input  wire logic [7:0] req_midi_byte,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_stall,
   input  wire logic [3:0] rsp_code_index,
   input  wire logic [7:0] rsp_byte0,
   input  wire logic [7:0] rsp_byte1,
   input  wire logic [7:0] rsp_byte2,
   output int              fail_count,
   output int              pending,
   output int              bytes_in,
   output int              packets_out
);
   import mtu_pkg::*;

   logic [1:0] fill_cnt;
   logic [1:0] need_cnt;
   logic       in_sysex;
   logic [7:0] voice_status;
   logic [6:0] held_data;
   logic       held_ok;
   logic [3:0] cur_cin;
   logic [7:0] sys_bytes [3];

   packet_type packet_q [$];
   int         fails   = 0;
   int         beats   = 0;
   int         packets = 0;

   function automatic logic [1:0] voice_bytes(input logic [7:0] status);
      return (status[7:4] == HI_PROG_CHG || status[7:4] == HI_CHAN_PRES) ? 2'd2 : 2'd3;
   endfunction

   function automatic logic [1:0] next_slot();
      return (fill_cnt > 2'd2) ? 2'd2 : fill_cnt;
   endfunction

   function automatic bit packetize(input logic [7:0] b, output packet_type pkt);
      logic [1:0] idx;
      logic [1:0] count;
      pkt = '0;
      if (b >= REALTIME_MIN) begin
         pkt = '{CIN_SINGLE, b, 8'h00, 8'h00};
         return 1'b1;
      end
      if (b == SYSEX_END && in_sysex) begin
         idx = next_slot();
         sys_bytes[idx] = b;
         count = idx + 2'd1;
         fill_cnt = 2'd0;
         in_sysex = 1'b0;
         pkt = '{CIN_SYSEX + 4'(count), sys_bytes[0],
                 (count > 2'd1) ? sys_bytes[1] : 8'h00,
                 (count > 2'd2) ? sys_bytes[2] : 8'h00};
         return 1'b1;
      end
      if (b[7]) begin
         fill_cnt = 2'd0;
         in_sysex = 1'b0;
         held_ok  = 1'b0;
         if (b < SYSEX_START) begin
            voice_status = b;
            cur_cin      = b[7:4];
            need_cnt     = voice_bytes(b);
            fill_cnt     = 2'd1;
            return 1'b0;
         end
         voice_status = 8'h00;
         if (b == SYSEX_START) begin
            in_sysex     = 1'b1;
            sys_bytes[0] = b;
            cur_cin      = CIN_SYSEX;
            need_cnt     = 2'd3;
            fill_cnt     = 2'd1;
            return 1'b0;
         end
         if (b == MTC_QUARTER || b == SONG_SEL || b == SONG_POS) begin
            sys_bytes[0] = b;
            cur_cin      = (b == SONG_POS) ? CIN_COMMON_3 : CIN_COMMON_2;
            need_cnt     = (b == SONG_POS) ? 2'd3 : 2'd2;
            fill_cnt     = 2'd1;
            return 1'b0;
         end
         pkt = '{CIN_SINGLE, b, 8'h00, 8'h00};
         return 1'b1;
      end
      if (in_sysex) begin
         idx = next_slot();
         sys_bytes[idx] = b;
         fill_cnt = idx + 2'd1;
         if (fill_cnt == 2'd3) begin
            fill_cnt = 2'd0;
            pkt = '{CIN_SYSEX, sys_bytes[0], sys_bytes[1], sys_bytes[2]};
            return 1'b1;
         end
         return 1'b0;
      end
      if (fill_cnt == 2'd0) begin
         // drop a stray data byte with no running status
         if (voice_status == 8'h00) return 1'b0;
         cur_cin  = voice_status[7:4];
         need_cnt = voice_bytes(voice_status);
         held_ok  = 1'b0;
         fill_cnt = 2'd1;
      end
      if (cur_cin >= CIN_VOICE) begin
         if (need_cnt == 2'd2) begin
            fill_cnt = 2'd0;
            pkt = '{cur_cin, voice_status, b, 8'h00};
            return 1'b1;
         end
         if (!held_ok) begin
            held_data = b[6:0];
            held_ok   = 1'b1;
            fill_cnt  = 2'd2;
            return 1'b0;
         end
         held_ok  = 1'b0;
         fill_cnt = 2'd0;
         pkt = '{cur_cin, voice_status, {1'b0, held_data}, b};
         return 1'b1;
      end
      idx = next_slot();
      sys_bytes[idx] = b;
      fill_cnt = idx + 2'd1;
      if (fill_cnt >= need_cnt) begin
         count = fill_cnt;
         fill_cnt = 2'd0;
         pkt = '{cur_cin, sys_bytes[0],
                 (count > 2'd1) ? sys_bytes[1] : 8'h00,
                 (count > 2'd2) ? sys_bytes[2] : 8'h00};
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic compare_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
      if (got !== want) begin
         fails++;
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      packet_type want_pkt;
      packet_type got_pkt;
      if (reset) begin
         fill_cnt     = 2'd0;
         need_cnt     = 2'd0;
         in_sysex     = 1'b0;
         voice_status = 8'h00;
         held_data    = 7'h00;
         held_ok      = 1'b0;
         cur_cin      = 4'h0;
         sys_bytes    = '{8'h00, 8'h00, 8'h00};
         packet_q.delete();
      end else begin
         if (req_valid && !req_stall) begin
            beats++;
            if (packetize(req_midi_byte, want_pkt)) packet_q.push_back(want_pkt);
         end
         if (rsp_valid && !rsp_stall) begin
            packets++;
            got_pkt = '{rsp_code_index, rsp_byte0, rsp_byte1, rsp_byte2};
            if (packet_q.size() == 0) begin
               fails++;
               $display("%0t: unexpected packet, expected none, got cin %h bytes %h %h %h",
                        $time, got_pkt.code_index, got_pkt.byte0, got_pkt.byte1,
                        got_pkt.byte2);
            end else begin
               want_pkt = packet_q.pop_front();
               compare_field("code_index", 8'(want_pkt.code_index), 8'(got_pkt.code_index));
               compare_field("byte0", want_pkt.byte0, got_pkt.byte0);
               compare_field("byte1", want_pkt.byte1, got_pkt.byte1);
               compare_field("byte2", want_pkt.byte2, got_pkt.byte2);
            end
         end
      end
      fail_count  <= fails;
      pending     <= packet_q.size();
      bytes_in    <= beats;
      packets_out <= packets;
   end

endmodule

// ===== bench/midi_to_usb_event_packetizer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI to USB event packetizer - bench top
// Drives a directed MIDI byte stream and then random, mostly well-formed
// voice, system common, SysEx and realtime traffic with random idling on
// both channels, a long receiver hold-off and drain pauses. The checker
// beside the block predicts and compares every packet.
// ----------------------------------------------------------------------------
module midi_to_usb_event_packetizer_test;
   import mtu_pkg::*;

   localparam int HOLD_CYCLES = 160;
   localparam int STALL_LIMIT = 3000;

   logic       clock;
   logic       reset         = 1'b1;
   logic       req_valid     = 1'b0;
   logic [7:0] req_midi_byte = 8'h00;
   logic       rsp_stall     = 1'b0;
   logic       req_stall;
   logic       rsp_valid;
   logic [3:0] rsp_code_index;
   logic [7:0] rsp_byte0;
   logic [7:0] rsp_byte1;
   logic [7:0] rsp_byte2;

   int fail_count;
   int pending;
   int bytes_in;
   int packets_out;

   bit tx_idle     = 1'b0;
   bit rx_idle     = 1'b0;
   int hold_asked  = 0;
   int hold_done   = 0;
   int bytes_sent  = 0;
   int quiet_run   = 0;

   logic [7:0] directed_seq [27];

   midi_to_usb_event_packetizer dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_midi_byte  (req_midi_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_code_index (rsp_code_index),
      .rsp_byte0      (rsp_byte0),
      .rsp_byte1      (rsp_byte1),
      .rsp_byte2      (rsp_byte2)
   );

   midi_to_usb_event_packetizer_check packet_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_midi_byte  (req_midi_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_code_index (rsp_code_index),
      .rsp_byte0      (rsp_byte0),
      .rsp_byte1      (rsp_byte1),
      .rsp_byte2      (rsp_byte2),
      .fail_count     (fail_count),
      .pending        (pending),
      .bytes_in       (bytes_in),
      .packets_out    (packets_out)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // receiver: random stall bursts and the requested long hold-off
   initial begin
      forever begin
         if (hold_done != hold_asked) begin
            hold_done = hold_asked;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (rx_idle && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   end

   initial begin
      while (quiet_run < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_run = 0;
         else
            quiet_run++;
      end
      $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
      $display("** midi_to_usb_event_packetizer: FAILED **");
      $finish;
   end

   task automatic send_byte(input logic [7:0] b);
      if (tx_idle && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_midi_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_data(input logic [7:0] b);
      if ($urandom_range(0, 15) == 0) send_byte(8'(REALTIME_MIN + $urandom_range(0, 7)));
      send_byte(b);
   endtask

   function automatic logic [7:0] data_byte();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'h7F;
         default: return 8'($urandom_range(0, 127));
      endcase
   endfunction

   function automatic logic [7:0] voice_status_byte();
      return 8'h80 | 8'($urandom_range(0, 6) << 4) | 8'($urandom_range(0, 15));
   endfunction

   task automatic send_message();
      logic [7:0] status;
      int         n_data;
      int         kind;
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
         status = voice_status_byte();
         n_data = (status[7:4] == 4'hC || status[7:4] == 4'hD) ? 1 : 2;
         send_data(status);
         repeat ($urandom_range(1, 4)) begin
            // truncate now and then
            if ($urandom_range(0, 19) == 0) n_data = $urandom_range(0, n_data);
            repeat (n_data) send_data(data_byte());
         end
      end else if (kind < 52) begin
         repeat ($urandom_range(1, 3)) send_data(data_byte());
      end else if (kind < 70) begin
         send_data(SYSEX_START);
         repeat ($urandom_range(0, 10)) send_data(data_byte());
         case ($urandom_range(0, 9))
            0: send_data(voice_status_byte());
            1: send_data(8'(SYSEX_START + $urandom_range(0, 6)));
            default: send_data(SYSEX_END);
         endcase
      end else if (kind < 80) begin
         case ($urandom_range(0, 2))
            0: status = MTC_QUARTER;
            1: status = SONG_SEL;
            default: status = SONG_POS;
         endcase
         n_data = (status == SONG_POS) ? 2 : 1;
         if ($urandom_range(0, 9) == 0) n_data = $urandom_range(0, n_data + 1);
         send_data(status);
         repeat (n_data) send_data(data_byte());
      end else if (kind < 86) begin
         send_data(8'($urandom_range(SONG_SEL + 1, SYSEX_END)));
      end else if (kind < 90) begin
         send_byte(8'($urandom_range(REALTIME_MIN, 8'hFF)));
      end else begin
         repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      directed_seq = '{
         8'h00,
         8'h90, 8'h3C, 8'h7F,
         8'h40, 8'h00,
         8'hB0, 8'h07, 8'hF8, 8'h64,
         SYSEX_START, 8'h01, 8'h02, 8'h03, 8'hFE, 8'h04, SYSEX_END,
         SONG_POS, 8'h01, 8'h02,
         8'hF4,
         SYSEX_END,
         SYSEX_START, 8'h11, 8'hC0,
         8'h7F,
         8'hFF
      };
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_seq[i]) send_byte(directed_seq[i]);
      drain();

      tx_idle = 1'b1;
      rx_idle = 1'b1;
      while (bytes_sent < 700) send_message();

      // hold the receiver and keep offering realtime beats until the input stalls
      tx_idle = 1'b0;
      hold_asked++;
      repeat (40) send_byte(8'(REALTIME_MIN + $urandom_range(0, 7)));
      drain();

      tx_idle = 1'b1;
      while (bytes_sent < 1450) begin
         if ($urandom_range(0, 39) == 0) begin
            tx_idle = !tx_idle;
            rx_idle = !rx_idle;
         end
         send_message();
      end
      drain();

      tx_idle = 1'b0;
      rx_idle = 1'b0;
      while (bytes_sent < 1750) send_message();
      drain();

      $display("Ran %0d MIDI bytes and checked %0d event packets", bytes_in, packets_out);
      $display("covering voice, running status, SysEx, system common, realtime, stalls");
      if (fail_count == 0 && pending == 0)
         $display("** midi_to_usb_event_packetizer: PASSED **");
      else
         $display("** midi_to_usb_event_packetizer: FAILED **");
      $finish;
   end

endmodule
